/* rtl/ipv4_route_lpm_table_assert.svh */
// Assertion macros for the route table.
`ifndef IPV4_ROUTE_LPM_TABLE_ASSERT_SVH
`define IPV4_ROUTE_LPM_TABLE_ASSERT_SVH

// Same-cycle implication.
`define LPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lpm_pkg.sv */
package lpm_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 32;

	localparam logic [5:0]  MAX_PREFIX = 6'd32;
	localparam logic [31:0] FULL_MASK  = 32'hFFFF_FFFF;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_NOMATCH = 3'd4;

	typedef struct packed {
		logic        action;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [15:0] route_metric;
		logic [3:0]  out_port;
		logic [31:0] gateway;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_subnet;
		logic [5:0]  found_prefix;
		logic [15:0] found_metric;
		logic [3:0]  found_port;
		logic [31:0] found_gateway;
	} rsp_t;

	typedef struct packed {
		logic [31:0] subnet;
		logic [5:0]  prefix;
		logic [15:0] metric;
		logic [3:0]  port;
		logic [31:0] gateway;
	} entry_t;

	typedef struct packed {
		logic       load;
		logic       action;
		logic [2:0] status;
		entry_t     entry;
	} result_t;

	function automatic logic [31:0] prefix_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) begin
			m = '0;
		end else if (len >= MAX_PREFIX) begin
			m = FULL_MASK;
		end else begin
			m = ~(FULL_MASK >> len[4:0]);
		end
		return m;
	endfunction

endpackage

/* rtl/lpm_chan_if.sv */
interface lpm_chan_if #(
	parameter type payload_t = logic [0:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/lpm_store.sv */
module lpm_store
	import lpm_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lpm_ctrl.sv */
module lpm_ctrl
	import lpm_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
	parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	lpm_chan_if.sink      req,
	input  logic          res_free,
	output result_t       res,
	output logic [CW-1:0] count,
	output logic          we,
	output logic [AW-1:0] waddr,
	output entry_t        wdata,
	output logic [AW-1:0] raddr,
	input  entry_t        rdata
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]    st_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic          rvalid_s1;
	req_t          item_q;
	logic          dup_q;
	logic          found_q;
	entry_t        best_q;

	logic          accept;
	logic          full;
	logic [CW-1:0] last_cnt;
	logic [AW-1:0] last_idx;
	logic          hit;
	logic          finish;

	assign req.ready = (st_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign last_cnt  = count_q - CW'(1);
	assign last_idx  = last_cnt[AW-1:0];
	assign raddr     = idx_q;
	assign count     = count_q;
	assign finish    = (st_q == S_DONE) && res_free;

	// shared compare unit: one stored entry per cycle
	assign hit = (((item_q.address ^ rdata.subnet) & prefix_mask(rdata.prefix)) == 32'd0);

	assign we    = finish && (item_q.action == ACT_INSERT) && !dup_q && !full;
	assign waddr = count_q[AW-1:0];

	always_comb begin
		wdata.subnet  = item_q.address;
		wdata.prefix  = (item_q.prefix_len > MAX_PREFIX) ? MAX_PREFIX : item_q.prefix_len;
		wdata.metric  = item_q.route_metric;
		wdata.port    = item_q.out_port;
		wdata.gateway = item_q.gateway;
	end

	always_comb begin
		res.load   = finish;
		res.action = item_q.action;
		res.entry  = '0;
		if (item_q.action == ACT_INSERT) begin
			if (dup_q) begin
				res.status = ST_DUP;
			end else if (full) begin
				res.status = ST_FULL;
			end else begin
				res.status = ST_OK;
			end
		end else if (count_q == '0) begin
			res.status = ST_EMPTY;
		end else if (found_q) begin
			res.status = ST_OK;
			res.entry  = best_q;
		end else begin
			res.status = ST_NOMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
			dup_q     <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rvalid_s1 <= (st_q == S_SCAN);
			if (rvalid_s1) begin
				if (rdata.subnet == item_q.address) begin
					dup_q <= 1'b1;
				end
				if (hit && (!found_q || (rdata.prefix > best_q.prefix))) begin
					found_q <= 1'b1;
				end
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						dup_q   <= 1'b0;
						found_q <= 1'b0;
						st_q    <= (count_q == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + AW'(1);
					if (idx_q == last_idx) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					st_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						st_q <= S_IDLE;
						if (we) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req.data;
		end
		if (rvalid_s1 && hit && (!found_q || (rdata.prefix > best_q.prefix))) begin
			best_q <= rdata;
		end
	end

endmodule

/* rtl/ipv4_route_lpm_table.sv */
// IPv4 longest-prefix-match route table.
// req carries one item per transfer: insert (action 0) appends a route unless
// its subnet is already stored or the table is full; lookup (action 1) returns
// the earliest stored entry with the longest matching prefix.
// rsp carries exactly one result per request, in order.
// The table is scanned one entry per cycle through a single registered memory
// read port feeding one compare unit. After the request transfer the controller
// steps through its scan, drain and done states (straight to done on an empty
// table) and then loads the result into the output register. req.ready is high
// only while idle, so a new request is taken only once the previous scan is done.
// Results sit in an output register; the next request may be taken while a
// result waits there. If rsp stalls, a finished scan holds until the register
// frees up.
// Reset empties the table (entry count to zero) and drops any pending result;
// the entry memory itself is not cleared.
module ipv4_route_lpm_table
	import lpm_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lpm_chan_if.sink   req,
	lpm_chan_if.source rsp
);

`include "ipv4_route_lpm_table_assert.svh"

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	result_t       res;
	logic [CW-1:0] count;
	logic          res_free;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [AW-1:0] raddr;
	entry_t        rdata;
	logic          rsp_v_q;
	rsp_t          rsp_q;

	lpm_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res_free(res_free),
		.res(res),
		.count(count),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	lpm_store #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign res_free  = !rsp_v_q || rsp.ready;
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (res.load) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			rsp_q.status        <= res.status;
			rsp_q.found_subnet  <= res.entry.subnet;
			rsp_q.found_prefix  <= res.entry.prefix;
			rsp_q.found_metric  <= res.entry.metric;
			rsp_q.found_port    <= res.entry.port;
			rsp_q.found_gateway <= res.entry.gateway;
		end
	end

	`LPM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count <= CW'(TABLE_DEPTH), "entry count past depth")
	`LPM_ASSERT_NOW(a_no_overwrite, clk, arst_n, res.load, res_free, "result loaded over pending one")
	`LPM_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready, "ready right after request")
	`LPM_ASSERT_NEXT(a_insert_grows, clk, arst_n, res.load && (res.action == ACT_INSERT) && (res.status == ST_OK), count == $past(count) + CW'(1), "insert did not grow table")

endmodule

/* tb/ipv4_route_lpm_table_test.sv */
`timescale 1ns / 100ps

module ipv4_route_lpm_table_test;
	import lpm_pkg::*;

	localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpm_chan_if #(.payload_t(req_t)) req_bus();
	lpm_chan_if #(.payload_t(rsp_t)) rsp_bus();

	ipv4_route_lpm_table #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	req_t        req_pending[$];
	rsp_t        rsp_expected[$];
	logic [31:0] gen_subnets[$];
	entry_t      tbl_entry[DEPTH];
	int          tbl_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	initial begin
		req_bus.valid = 1'b0;
		req_bus.data = '0;
		rsp_bus.ready = 1'b0;
	end

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic rsp_t lpm_predict(input req_t r);
		rsp_t        res;
		entry_t      e;
		logic        hit;
		int          best;
		logic [31:0] m;
		res = '0;
		hit = 1'b0;
		best = 0;
		if (r.action == ACT_INSERT) begin
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_entry[i].subnet == r.address)
					hit = 1'b1;
			end
			if (hit) begin
				res.status = ST_DUP;
			end else if (tbl_count >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				e.subnet = r.address;
				e.prefix = (r.prefix_len > MAX_PREFIX) ? MAX_PREFIX : r.prefix_len;
				e.metric = r.route_metric;
				e.port = r.out_port;
				e.gateway = r.gateway;
				tbl_entry[tbl_count] = e;
				tbl_count++;
				res.status = ST_OK;
			end
		end else if (tbl_count == 0) begin
			res.status = ST_EMPTY;
		end else begin
			for (int i = 0; i < tbl_count; i++) begin
				m = (tbl_entry[i].prefix == 6'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> tbl_entry[i].prefix);
				if (((r.address ^ tbl_entry[i].subnet) & m) == 32'h0) begin
					if (!hit || tbl_entry[i].prefix > tbl_entry[best].prefix) begin
						best = i;
						hit = 1'b1;
					end
				end
			end
			if (!hit) begin
				res.status = ST_NOMATCH;
			end else begin
				res.status = ST_OK;
				res.found_subnet = tbl_entry[best].subnet;
				res.found_prefix = tbl_entry[best].prefix;
				res.found_metric = tbl_entry[best].metric;
				res.found_port = tbl_entry[best].port;
				res.found_gateway = tbl_entry[best].gateway;
			end
		end
		return res;
	endfunction

	task automatic check_rsp(input rsp_t got, input rsp_t want);
		if (got.status !== want.status)
			report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.found_subnet !== want.found_subnet)
			report_mismatch($sformatf("found_subnet %h, want %h", got.found_subnet,
				want.found_subnet));
		if (got.found_prefix !== want.found_prefix)
			report_mismatch($sformatf("found_prefix %0d, want %0d", got.found_prefix,
				want.found_prefix));
		if (got.found_metric !== want.found_metric)
			report_mismatch($sformatf("found_metric %h, want %h", got.found_metric,
				want.found_metric));
		if (got.found_port !== want.found_port)
			report_mismatch($sformatf("found_port %0d, want %0d", got.found_port,
				want.found_port));
		if (got.found_gateway !== want.found_gateway)
			report_mismatch($sformatf("found_gateway %h, want %h", got.found_gateway,
				want.found_gateway));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.data <= '0;
		end else if (!req_bus.valid || req_bus.ready) begin
			if (req_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				req_bus.valid <= 1'b1;
				req_bus.data <= req_pending.pop_front();
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_bus.ready <= 1'b0;
		else
			rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor: check the result transfer first, then predict for the request transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (rsp_expected.size() == 0)
					report_mismatch($sformatf("result with nothing pending, status %0d",
						rsp_bus.data.status));
				else
					check_rsp(rsp_bus.data, rsp_expected.pop_front());
			end
			if (req_bus.valid && req_bus.ready)
				rsp_expected = {rsp_expected, lpm_predict(req_bus.data)};
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", quiet_cycles);
			$display("[ipv4_route_lpm_table] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic req_t mk_insert(input logic [31:0] addr, input logic [5:0] plen,
		input logic [15:0] metric, input logic [3:0] port, input logic [31:0] gw);
		req_t r;
		r.action = ACT_INSERT;
		r.address = addr;
		r.prefix_len = plen;
		r.route_metric = metric;
		r.out_port = port;
		r.gateway = gw;
		return r;
	endfunction

	function automatic req_t mk_lookup(input logic [31:0] addr);
		req_t r;
		r = mk_insert(addr, 6'($urandom_range(63)), 16'($urandom()), 4'($urandom()), $urandom());
		r.action = ACT_LOOKUP;
		return r;
	endfunction

	// tracks which subnets will be stored so random lookups can aim at them
	task automatic push_item(input req_t r);
		logic dup;
		dup = 1'b0;
		if (r.action == ACT_INSERT) begin
			foreach (gen_subnets[i]) begin
				if (gen_subnets[i] == r.address)
					dup = 1'b1;
			end
			if (!dup && gen_subnets.size() < DEPTH)
				gen_subnets = {gen_subnets, r.address};
		end
		req_pending = {req_pending, r};
	endtask

	function automatic logic [31:0] low_bits(input int k);
		return (32'h1 << k) - 32'h1;
	endfunction

	function automatic logic [31:0] some_subnet();
		return gen_subnets[$urandom_range(gen_subnets.size() - 1)];
	endfunction

	task automatic push_random(input logic table_can_grow);
		int          sel;
		logic [31:0] addr;
		logic [5:0]  plen;
		sel = $urandom_range(99);
		if (sel < 9 && (!table_can_grow || gen_subnets.size() < DEPTH - 1)) begin
			addr = (gen_subnets.size() > 0 && $urandom_range(1)) ?
				some_subnet() ^ ($urandom() & low_bits($urandom_range(24))) : $urandom();
			if ($urandom_range(7) == 0)
				plen = 6'($urandom_range(33, 63));
			else
				plen = 6'($urandom_range(table_can_grow ? 1 : 0, 32));
			push_item(mk_insert(addr, plen, 16'($urandom()), 4'($urandom()), $urandom()));
		end else if (sel < 13 && gen_subnets.size() > 0) begin
			push_item(mk_insert(some_subnet(), 6'($urandom_range(63)), 16'($urandom()),
				4'($urandom()), $urandom()));
		end else if (sel < 83 && gen_subnets.size() > 0) begin
			push_item(mk_lookup(some_subnet() ^ ($urandom() & low_bits($urandom_range(32)))));
		end else begin
			push_item(mk_lookup($urandom()));
		end
	endtask

	task automatic wait_drained();
		while (req_pending.size() > 0 || req_bus.valid)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 11;
		recv_idle_pct = 49;
		push_item(mk_lookup(32'h0000_0000));
		push_item(mk_lookup(32'hFFFF_FFFF));
		push_item(mk_insert(32'h0A00_0000, 6'd8, 16'h0000, 4'h0, 32'h0000_0000));
		push_item(mk_lookup(32'hC0A8_0101));
		push_item(mk_lookup(32'h0A7F_0001));
		push_item(mk_insert(32'hFFFF_FFFF, 6'd63, 16'hFFFF, 4'hF, 32'hFFFF_FFFF));
		push_item(mk_lookup(32'hFFFF_FFFF));
		push_item(mk_lookup(32'hFFFF_FFFE));
		push_item(mk_insert(32'h0A00_0000, 6'd24, 16'h1111, 4'h1, 32'h0101_0101));
		push_item(mk_insert(32'h0A01_0203, 6'd16, 16'h1234, 4'h5, 32'hC0A8_0001));
		push_item(mk_insert(32'h0A01_FF00, 6'd16, 16'h4321, 4'h6, 32'hC0A8_0002));
		push_item(mk_lookup(32'h0A01_AAAA));
		push_item(mk_insert(32'h0A01_0200, 6'd24, 16'h0024, 4'h7, 32'hC0A8_0003));
		push_item(mk_lookup(32'h0A01_02FF));
		push_item(mk_lookup(32'h0A02_FFFF));
		push_item(mk_insert(32'h0000_0000, 6'd32, 16'h8000, 4'h8, 32'h7FFF_FFFF));
		push_item(mk_lookup(32'h0000_0000));
		push_item(mk_insert(32'h8000_0000, 6'd1, 16'h0001, 4'h9, 32'h8000_0001));
		push_item(mk_lookup(32'hFFFF_FFFE));
		push_item(mk_insert(32'h0A01_0203, 6'd0, 16'hAAAA, 4'hA, 32'hAAAA_AAAA));
		push_item(mk_insert(32'hC0A8_0000, 6'd33, 16'h5555, 4'h3, 32'h5555_5555));
		push_item(mk_lookup(32'hC0A8_0000));
		repeat (278) push_random(1'b1);
		wait_drained();

		send_idle_pct = 49;
		recv_idle_pct = 11;
		repeat (300) push_random(1'b1);
		wait_drained();

		// catch-all route goes in last, after the no-match cases are done
		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_item(mk_insert(32'h0102_0304, 6'd0, 16'h0F0F, 4'h2, 32'h0A0A_0A0A));
		push_item(mk_lookup($urandom()));
		repeat (250) push_random(1'b0);
		wait_drained();

		while (rsp_expected.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ipv4_route_lpm_table] OK");
		else
			$display("[ipv4_route_lpm_table] ERROR");
		$finish;
	end

endmodule
